[rtl/core/tbemf_pkg.sv]
// Shared types, constants and coefficient tables for the type B EMF to
// temperature converter. No dependencies; imported by every rtl/core module.
package tbemf_pkg;

	// Port and datapath widths
	localparam int EMF_W    = 14;
	localparam int TEMP_W   = 18;
	localparam int X_W      = 24;   // EMF in mV, 20 fractional bits
	localparam int ACC_W    = 57;   // Horner accumulator, 40 fractional bits
	localparam int XFRAC_W  = 20;
	localparam int CFRAC_W  = 40;
	localparam int N_W      = 21;   // numerator of the divide by 125
	localparam int Q_W      = 15;   // quotient of the divide by 125
	localparam int CENT_W   = 23;

	localparam int MAX_TERMS      = 12;
	localparam int POLY_TERMS_DEF = 9;

	// Range limits in microvolts and output ceiling
	localparam logic [EMF_W-1:0]  EMF_LOW_UV     = EMF_W'(291);
	localparam logic [EMF_W-1:0]  EMF_SPLIT_UV   = EMF_W'(2431);
	localparam logic [EMF_W-1:0]  EMF_HIGH_UV    = EMF_W'(13820);
	localparam logic [CENT_W-1:0] TEMP_MAX_CENTI = CENT_W'(200000);

	// x = uv*1048 + floor((uv*72 + 62) / 125); the divide is a reciprocal multiply
	localparam int UV_INT_MUL  = 1048;
	localparam int UV_FRAC_MUL = 72;
	localparam int UV_FRAC_ADD = 62;
	localparam logic [N_W-1:0] RECIP_125 = N_W'(1073742);
	localparam int RECIP_SH    = 27;

	// Coefficients as mantissa / 10^dexp, eight significant digits
	localparam int LO_MANT [MAX_TERMS] = '{98423321, 69971500, -84765304, 10052644,
		-83345952, 45508542, -15523037, 29886750, -24742860, 0, 0, 0};
	localparam int LO_DEXP [MAX_TERMS] = '{6, 5, 5, 4, 5, 5, 5, 6, 7, 0, 0, 0};
	localparam int HI_MANT [MAX_TERMS] = '{21315071, 28510504, -52742887, 99160804,
		-12965303, 11195870, -60625199, 18661696, -24878585, 0, 0, 0};
	localparam int HI_DEXP [MAX_TERMS] = '{5, 5, 6, 7, 7, 8, 10, 11, 13, 0, 0, 0};

	// Word passed between pipeline sections
	typedef struct packed {
		logic             vld;
		logic             oor;
		logic             hiset;
		logic [X_W-1:0]   x;
		logic [ACC_W-1:0] acc;
	} tok_t;

	// round(mant / 10^dexp * 2^40), ties away from zero; elaboration only
	function automatic logic [63:0] coef_q40(input int mant, input int dexp);
		logic        neg;
		logic [63:0] m;
		logic [63:0] d;
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] f;
		logic [63:0] v;
		neg = (mant < 0);
		m = neg ? 64'(-longint'(mant)) : 64'(longint'(mant));
		d = 64'd1;
		for (int i = 0; i < dexp; i++) begin
			d = d * 64'd10;
		end
		q = '0;
		r = '0;
		for (int i = 31; i >= 0; i--) begin
			r = {r[62:0], m[i]};
			q = {q[62:0], 1'b0};
			if (r >= d) begin
				r = r - d;
				q[0] = 1'b1;
			end
		end
		f = '0;
		for (int i = 0; i < 41; i++) begin
			r = {r[62:0], 1'b0};
			f = {f[62:0], 1'b0};
			if (r >= d) begin
				r = r - d;
				f[0] = 1'b1;
			end
		end
		v = (q << 40) + ((f + 64'd1) >> 1);
		return neg ? (64'd0 - v) : v;
	endfunction

	function automatic logic [ACC_W-1:0] coef_sel(input logic hiset, input int idx);
		logic [63:0] lo;
		logic [63:0] hi;
		lo = coef_q40(LO_MANT[idx], LO_DEXP[idx]);
		hi = coef_q40(HI_MANT[idx], HI_DEXP[idx]);
		return hiset ? hi[ACC_W-1:0] : lo[ACC_W-1:0];
	endfunction

endpackage

[rtl/core/tbemf_front.sv]
// Input section: range check, set select and conversion of microvolts to
// millivolts in Q20 (three stages). Depends on tbemf_pkg.
module tbemf_front #(
	parameter int POLY_TERMS = tbemf_pkg::POLY_TERMS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  logic [tbemf_pkg::EMF_W-1:0] uv,
	output tbemf_pkg::tok_t             tok
);
	import tbemf_pkg::*;

	localparam logic [ACC_W-1:0] TOP_LO = coef_sel(1'b0, POLY_TERMS - 1);
	localparam logic [ACC_W-1:0] TOP_HI = coef_sel(1'b1, POLY_TERMS - 1);

	logic             vld_s1, vld_s2, vld_s3;
	logic             oor_s1, oor_s2, oor_s3;
	logic             hiset_s1, hiset_s2, hiset_s3;
	logic [EMF_W-1:0] uv_s1;
	logic [N_W-1:0]   n_s1;
	logic [2*N_W-1:0] prod_s2;
	logic [X_W-1:0]   base_s2;
	logic [X_W-1:0]   x_s3;
	logic [ACC_W-1:0] acc_s3;

	logic [N_W-1:0]   n_d;
	logic [2*N_W-1:0] prod_d;
	logic [X_W-1:0]   base_d;
	logic [Q_W-1:0]   q_d;

	// Stage 1 logic: numerator of the fractional part
	assign n_d = N_W'(uv) * N_W'(UV_FRAC_MUL) + N_W'(UV_FRAC_ADD);

	// Stage 2 logic: reciprocal multiply and integer part
	assign prod_d = (2*N_W)'(n_s1) * (2*N_W)'(RECIP_125);
	assign base_d = X_W'(uv_s1) * X_W'(UV_INT_MUL);

	// Stage 3 logic: quotient by 125
	assign q_d = prod_s2[RECIP_SH +: Q_W];

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Data path
	always_ff @(posedge clk) begin
		uv_s1    <= uv;
		n_s1     <= n_d;
		oor_s1   <= (uv < EMF_LOW_UV) || (uv > EMF_HIGH_UV);
		hiset_s1 <= (uv >= EMF_SPLIT_UV);
		prod_s2  <= prod_d;
		base_s2  <= base_d;
		oor_s2   <= oor_s1;
		hiset_s2 <= hiset_s1;
		x_s3     <= base_s2 + X_W'(q_d);
		acc_s3   <= hiset_s2 ? TOP_HI : TOP_LO;
		oor_s3   <= oor_s2;
		hiset_s3 <= hiset_s2;
	end

	assign tok.vld   = vld_s3;
	assign tok.oor   = oor_s3;
	assign tok.hiset = hiset_s3;
	assign tok.x     = x_s3;
	assign tok.acc   = acc_s3;

endmodule

[rtl/core/tbemf_step.sv]
// One Horner step acc = round(acc * x / 2^20) + c, as a multiply stage and an
// add stage. Depends on tbemf_pkg.
module tbemf_step #(
	parameter int COEF_IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tbemf_pkg::tok_t tin,
	output tbemf_pkg::tok_t tout
);
	import tbemf_pkg::*;

	localparam int MAG_W = ACC_W - 1;
	localparam int PHI_W = MAG_W - XFRAC_W + X_W;
	localparam int PLO_W = XFRAC_W + X_W;
	localparam int RND_W = PLO_W + 1 - XFRAC_W;
	localparam logic [ACC_W-1:0] C_LO = coef_sel(1'b0, COEF_IDX);
	localparam logic [ACC_W-1:0] C_HI = coef_sel(1'b1, COEF_IDX);

	logic             neg_d;
	logic [ACC_W-1:0] abs_d;
	logic [MAG_W-1:0] mag_d;

	logic             vld_s1, oor_s1, hiset_s1, neg_s1;
	logic [X_W-1:0]   x_s1;
	logic [PHI_W-1:0] p_hi_s1;
	logic [PLO_W-1:0] p_lo_s1;

	logic [PLO_W:0]   lo_sum;
	logic [RND_W-1:0] rnd;
	logic [ACC_W-1:0] r_mag;
	logic [ACC_W-1:0] coef;

	logic             vld_s2, oor_s2, hiset_s2;
	logic [X_W-1:0]   x_s2;
	logic [ACC_W-1:0] acc_s2;

	// Multiply stage: sign-magnitude split, two partial products
	assign neg_d = tin.acc[ACC_W-1];
	assign abs_d = neg_d ? (ACC_W'(0) - tin.acc) : tin.acc;
	assign mag_d = abs_d[MAG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= tin.vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		oor_s1   <= tin.oor;
		hiset_s1 <= tin.hiset;
		x_s1     <= tin.x;
		neg_s1   <= neg_d;
		p_hi_s1  <= PHI_W'(mag_d[MAG_W-1:XFRAC_W]) * PHI_W'(tin.x);
		p_lo_s1  <= PLO_W'(mag_d[XFRAC_W-1:0]) * PLO_W'(tin.x);
	end

	// Add stage: round low part, restore sign, add coefficient
	assign lo_sum = (PLO_W+1)'(p_lo_s1) + ((PLO_W+1)'(1) << (XFRAC_W - 1));
	assign rnd    = lo_sum[PLO_W:XFRAC_W];
	assign r_mag  = p_hi_s1[ACC_W-1:0] + ACC_W'(rnd);
	assign coef   = hiset_s1 ? C_HI : C_LO;

	always_ff @(posedge clk) begin
		oor_s2   <= oor_s1;
		hiset_s2 <= hiset_s1;
		x_s2     <= x_s1;
		acc_s2   <= neg_s1 ? (coef - r_mag) : (coef + r_mag);
	end

	assign tout.vld   = vld_s2;
	assign tout.oor   = oor_s2;
	assign tout.hiset = hiset_s2;
	assign tout.x     = x_s2;
	assign tout.acc   = acc_s2;

endmodule

[rtl/core/tbemf_scale.sv]
// Output section: Q40 degrees to hundredths, clamp and out-of-range zeroing
// (two stages, the second is the output register). Depends on tbemf_pkg.
module tbemf_scale (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tbemf_pkg::tok_t              tin,
	output logic                         out_vld,
	output logic [tbemf_pkg::TEMP_W-1:0] temp_centi,
	output logic                         out_of_range
);
	import tbemf_pkg::*;

	localparam int INT_W  = ACC_W - 1 - CFRAC_W;
	localparam int HI_W   = INT_W + 7;
	localparam int LO_W   = CFRAC_W + 7;
	localparam int LOR_W  = LO_W - CFRAC_W;

	logic [LO_W-1:0]   lo_d;

	logic              vld_s1, oor_s1, neg_s1;
	logic [HI_W-1:0]   hi100_s1;
	logic [LOR_W-1:0]  lor_s1;

	logic [CENT_W-1:0] cent;
	logic [CENT_W-1:0] cent_sat;

	logic              vld_q;
	logic              oor_q;
	logic [TEMP_W-1:0] temp_q;

	// Integer and rounded fractional parts times 100
	assign lo_d = LO_W'(tin.acc[CFRAC_W-1:0]) * LO_W'(100) + (LO_W'(1) << (CFRAC_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			vld_s1 <= tin.vld;
			vld_q  <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		oor_s1   <= tin.oor;
		neg_s1   <= tin.acc[ACC_W-1];
		hi100_s1 <= HI_W'(tin.acc[ACC_W-2:CFRAC_W]) * HI_W'(100);
		lor_s1   <= lo_d[LO_W-1:CFRAC_W];
	end

	// Sum, clamp, zero on negative or out of range
	assign cent     = CENT_W'(hi100_s1) + CENT_W'(lor_s1);
	assign cent_sat = (cent > TEMP_MAX_CENTI) ? TEMP_MAX_CENTI : cent;

	always_ff @(posedge clk) begin
		oor_q  <= oor_s1;
		temp_q <= (oor_s1 || neg_s1) ? '0 : cent_sat[TEMP_W-1:0];
	end

	assign out_vld      = vld_q;
	assign temp_centi   = temp_q;
	assign out_of_range = oor_q;

endmodule

[rtl/core/type_b_emf_to_temperature.sv]
// Top level of the type B thermocouple EMF to temperature converter.
// Depends on tbemf_pkg, tbemf_front, tbemf_step and tbemf_scale.
//
// Usage:
//  - Input: drive emf_uv (microvolts) and pulse start. A word is taken at
//    every rising edge with start high and busy low. busy is always low:
//    one word can be taken every cycle.
//  - Output: done is high for one cycle with temp_centi (0.01 degC) and
//    out_of_range. The receiver must take the word in that cycle.
//  - Pipeline: three input stages (range check, reciprocal multiply for the
//    mV conversion, Q20 sum), two stages per Horner step (partial products,
//    round and add), two output stages.
//  - Throughput: one word per cycle; each Horner step has its own
//    multipliers, so nothing is shared between words in flight.
//  - Results leave in the order the samples came in.
//  - Out of range samples (below 291 or above 13820 uV) give zero with
//    out_of_range set; negative results clamp to zero, large ones to 200000.
//  - Reset clears all valid bits; words in flight are dropped.
module type_b_emf_to_temperature #(
	parameter int POLY_TERMS = tbemf_pkg::POLY_TERMS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [tbemf_pkg::EMF_W-1:0]  emf_uv,
	output logic                         done,
	output logic [tbemf_pkg::TEMP_W-1:0] temp_centi,
	output logic                         out_of_range
);
	import tbemf_pkg::*;

	tok_t chain [POLY_TERMS];

	// Fully pipelined: never holds off the sender
	assign busy = 1'b0;

	tbemf_front #(
		.POLY_TERMS(POLY_TERMS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (start),
		.uv     (emf_uv),
		.tok    (chain[0])
	);

	// Horner chain, highest coefficient first
	for (genvar g = 0; g < POLY_TERMS - 1; g++) begin : g_step
		tbemf_step #(
			.COEF_IDX(POLY_TERMS - 2 - g)
		) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.tin    (chain[g]),
			.tout   (chain[g+1])
		);
	end

	tbemf_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.tin          (chain[POLY_TERMS-1]),
		.out_vld      (done),
		.temp_centi   (temp_centi),
		.out_of_range (out_of_range)
	);

endmodule

[rtl/core/tbemf_chk.sv]
// Port-level checks for type_b_emf_to_temperature, bound to the top level.
// Depends on tbemf_pkg.
module tbemf_chk #(
	parameter int POLY_TERMS = tbemf_pkg::POLY_TERMS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [tbemf_pkg::EMF_W-1:0]  emf_uv,
	input logic                         done,
	input logic [tbemf_pkg::TEMP_W-1:0] temp_centi,
	input logic                         out_of_range
);
	import tbemf_pkg::*;

	localparam int LAT = 2 * POLY_TERMS + 3;

	// Every result traces back to an earlier accepted word
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without matching input word");

	// Range flag follows the sample that produced it
	a_oor_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (out_of_range ==
			(($past(emf_uv, LAT) < EMF_LOW_UV) || ($past(emf_uv, LAT) > EMF_HIGH_UV))))
		else $error("out_of_range does not match input sample");

	// Out of range words carry zero
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_of_range) |-> (temp_centi == '0))
		else $error("nonzero temperature with out_of_range");

	// Clamp holds
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (CENT_W'(temp_centi) <= TEMP_MAX_CENTI))
		else $error("temperature above ceiling");

endmodule

bind type_b_emf_to_temperature tbemf_chk #(
	.POLY_TERMS(POLY_TERMS)
) u_tbemf_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.emf_uv       (emf_uv),
	.done         (done),
	.temp_centi   (temp_centi),
	.out_of_range (out_of_range)
);
